>>> design/setq_pkg.sv
// Shared types and codes for the sorted expiry timer queue.
package setq_pkg;

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_EXPIRE = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    localparam logic [2:0] RES_ACCEPTED = 3'd0;
    localparam logic [2:0] RES_EXPIRED  = 3'd1;
    localparam logic [2:0] RES_NONE     = 3'd2;
    localparam logic [2:0] RES_CLEARED  = 3'd3;
    localparam logic [2:0] RES_DROPPED  = 3'd4;

    localparam int unsigned EXP_CNT_W = 6;
    localparam logic [EXP_CNT_W-1:0] MAX_OUT = 6'd32;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] timer_id;
        logic [31:0] buff_id;
        logic [47:0] end_time;
        logic [47:0] now_time;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [31:0] expired_id;
        logic [31:0] expired_buff;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [47:0] end_time;
        logic [31:0] timer_id;
        logic [31:0] buff_id;
    } entry_t;

    typedef struct packed {
        logic insert;
        logic pop;
        logic clear;
    } cell_ctl_t;

endpackage

>>> design/sorted_expiry_timer_queue.sv
// Top level of the sorted expiry timer queue: cell chain, control and output register.
//
//   channel | signals                  | direction | payload
//   in      | in_valid, in_stall       | into      | in_item  (in_item_t)
//   out     | out_valid, out_stall     | out of    | out_item (out_item_t)
//
// Add, clear and ignored kinds are handled when accepted; the sorted insert
// happens in every cell of the chain at once, each comparing its own end time.
// Expire first latches the time, then gives one result per cycle while out is
// not stalled (n due entries, at most 32, or a single none result): the head
// cell is popped and the chain shifts left; in stays stalled until the last result.
// Reset empties the chain at once. A stall on out holds the output register and
// pauses the expire walk; in is stalled while an expire walk runs.
module sorted_expiry_timer_queue
    import setq_pkg::*;
#(
    parameter int unsigned CAPACITY = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item
);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_EXPIRE = 1'b1;

    logic                 state_reg, state_next;
    logic [EXP_CNT_W-1:0] cnt_reg, cnt_next;
    logic [47:0]          now_reg, now_next;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_item_reg, out_item_next;

    cell_ctl_t            ctl;
    entry_t               new_entry;
    entry_t               cell_entry [CAPACITY];
    logic [CAPACITY-1:0]  valid_vec;
    logic [CAPACITY-1:0]  le_vec;

    logic in_fire;
    logic out_free;
    logic full;
    logic head_due;
    logic next_due;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign in_fire   = in_valid && !in_stall;
    assign full      = valid_vec[CAPACITY-1];
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign new_entry.end_time = in_item.end_time;
    assign new_entry.timer_id = in_item.timer_id;
    assign new_entry.buff_id  = in_item.buff_id;

    assign head_due = valid_vec[0] && (cell_entry[0].end_time <= now_reg)
                      && (cnt_reg < MAX_OUT);
    assign next_due = valid_vec[1] && (cell_entry[1].end_time <= now_reg)
                      && (cnt_reg < MAX_OUT - 1'b1);

    assign ctl.insert = in_fire && (in_item.kind == KIND_ADD) && !full;
    assign ctl.clear  = in_fire && (in_item.kind == KIND_CLEAR);
    assign ctl.pop    = (state_reg == ST_EXPIRE) && out_free && head_due;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            entry_t left_e, right_e;
            logic   left_v, left_l, right_v;

            if (gi == 0)
            begin : g_head
                assign left_e = new_entry;
                assign left_v = 1'b0;
                assign left_l = 1'b1;
            end
            else
            begin : g_mid
                assign left_e = cell_entry[gi-1];
                assign left_v = valid_vec[gi-1];
                assign left_l = le_vec[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign right_e = new_entry;
                assign right_v = 1'b0;
            end
            else
            begin : g_body
                assign right_e = cell_entry[gi+1];
                assign right_v = valid_vec[gi+1];
            end

            setq_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .new_entry   (new_entry),
                .left_entry  (left_e),
                .left_valid  (left_v),
                .left_le     (left_l),
                .right_entry (right_e),
                .right_valid (right_v),
                .entry       (cell_entry[gi]),
                .valid       (valid_vec[gi]),
                .le          (le_vec[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        now_next       = now_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_item_next  = out_item_reg;

        if (in_fire)
        begin
            unique case (in_item.kind)
                KIND_ADD:
                begin
                    out_valid_next             = 1'b1;
                    out_item_next.result_kind  = full ? RES_DROPPED : RES_ACCEPTED;
                    out_item_next.expired_id   = '0;
                    out_item_next.expired_buff = '0;
                    out_item_next.last         = 1'b1;
                end
                KIND_EXPIRE:
                begin
                    state_next = ST_EXPIRE;
                    cnt_next   = '0;
                    now_next   = in_item.now_time;
                end
                KIND_CLEAR:
                begin
                    out_valid_next             = 1'b1;
                    out_item_next.result_kind  = RES_CLEARED;
                    out_item_next.expired_id   = '0;
                    out_item_next.expired_buff = '0;
                    out_item_next.last         = 1'b1;
                end
                default:
                begin
                    // drop unused kind without a result
                end
            endcase
        end
        else if ((state_reg == ST_EXPIRE) && out_free)
        begin
            out_valid_next = 1'b1;
            if (head_due)
            begin
                out_item_next.result_kind  = RES_EXPIRED;
                out_item_next.expired_id   = cell_entry[0].timer_id;
                out_item_next.expired_buff = cell_entry[0].buff_id;
                out_item_next.last         = !next_due;
                cnt_next                   = cnt_reg + 1'b1;
                if (!next_due)
                begin
                    state_next = ST_IDLE;
                end
            end
            else
            begin
                out_item_next.result_kind  = RES_NONE;
                out_item_next.expired_id   = '0;
                out_item_next.expired_buff = '0;
                out_item_next.last         = 1'b1;
                state_next                 = ST_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg      <= now_next;
        out_item_reg <= out_item_next;
    end

    // Occupied cells always form a contiguous run from the head.
    a_thermometer: assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_vec & (valid_vec + 1'b1)) == '0))
        else $error("chain occupancy is not contiguous");

    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXPIRE) |-> in_stall)
        else $error("input open during expire walk");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg <= MAX_OUT))
        else $error("expire count beyond limit");

    a_pop_emits: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop |=> (out_valid && (out_item.result_kind == RES_EXPIRED)))
        else $error("popped entry not presented");

endmodule

>>> design/setq_cell.sv
// One slot of the sorted chain: holds an entry, inserts in order, shifts on pop.
module setq_cell
    import setq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_ctl_t ctl,
    input  entry_t    new_entry,
    input  entry_t    left_entry,
    input  logic      left_valid,
    input  logic      left_le,
    input  entry_t    right_entry,
    input  logic      right_valid,
    output entry_t    entry,
    output logic      valid,
    output logic      le
);

    entry_t entry_reg;
    logic   valid_reg;

    // Entries with an equal end time stay ahead of the new one.
    assign le    = valid_reg && (entry_reg.end_time <= new_entry.end_time);
    assign entry = entry_reg;
    assign valid = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.insert && !le)
        begin
            valid_reg <= left_le ? 1'b1 : left_valid;
        end
        else if (ctl.pop)
        begin
            valid_reg <= right_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.insert && !le)
        begin
            // take the new entry at the boundary, shift right behind it
            entry_reg <= left_le ? new_entry : left_entry;
        end
        else if (ctl.pop)
        begin
            entry_reg <= right_entry;
        end
    end

endmodule

>>> sim/tb_sorted_expiry_timer_queue.sv
// Testbench for the sorted expiry timer queue: directed table, then random timer traffic.
`timescale 1ns / 100ps

module tb_sorted_expiry_timer_queue;
    import setq_pkg::*;

    localparam int unsigned CAPACITY     = 32;
    localparam int unsigned RUN_LIMIT    = 200000;
    localparam int unsigned DRAIN_WAIT   = 40;
    localparam int unsigned HOLD_AT      = 30;
    localparam int unsigned HOLD_LEN     = 300;
    localparam int unsigned RANDOM_ITEMS = 100;
    localparam int unsigned FILL_AT      = 60;
    localparam logic [1:0]  KIND_UNUSED  = 2'd3;
    localparam logic [47:0] TIME_MAX     = 48'hFFFF_FFFF_FFFF;

    localparam int unsigned STALL_NEVER  = 0;
    localparam int unsigned STALL_LIGHT  = 1;
    localparam int unsigned STALL_HEAVY  = 2;

    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t result;
        bit        wait_idle;
    } stim_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_item_t  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_item;

    entry_t      pending_timers[$];
    out_item_t   due_results[$];
    out_item_t   step_results[$];
    stim_row_t   stim_rows[$];
    out_item_t   oldest_due;

    int unsigned stim_idx = 0;
    int unsigned transfers = 0;
    int unsigned fail_count = 0;
    int unsigned burst_left = 4;
    int unsigned gap_left = 0;
    int unsigned hold_left = 0;
    int unsigned stall_mode = STALL_NEVER;
    int unsigned mode_left = 0;
    int unsigned phase_cnt = 0;
    int unsigned cycle_count = 0;
    bit          hold_done = 1'b0;
    bit          feed_done = 1'b0;

    sorted_expiry_timer_queue #(.CAPACITY(CAPACITY)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic out_item_t make_result(logic [2:0] rk, logic [31:0] id,
                                              logic [31:0] buff, logic fin);
        out_item_t r;
        r.result_kind  = rk;
        r.expired_id   = id;
        r.expired_buff = buff;
        r.last         = fin;
        return r;
    endfunction

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic in_item_t pack_item(logic [1:0] k, logic [31:0] id, logic [31:0] buff,
                                           logic [47:0] endt, logic [47:0] now);
        in_item_t it;
        it.kind     = k;
        it.timer_id = id;
        it.buff_id  = buff;
        it.end_time = endt;
        it.now_time = now;
        return it;
    endfunction

    // Rows that are not typed take their expected results from the timer model.
    function automatic void add_row(in_item_t it, bit typed, logic [2:0] rk, bit wait_idle);
        stim_row_t row;
        row.item      = it;
        row.typed     = typed;
        row.result    = make_result(rk, '0, '0, 1'b1);
        row.wait_idle = wait_idle;
        stim_rows.insert(stim_rows.size(), row);
    endfunction

    // Apply one transfer to the sorted timer list and collect its results.
    function automatic void model_timer_op(in_item_t it);
        entry_t    e;
        out_item_t r;
        int        pos;
        int        n;
        step_results.delete();
        case (it.kind)
            KIND_ADD:
            begin
                if (pending_timers.size() >= CAPACITY)
                    step_results.insert(step_results.size(),
                                        make_result(RES_DROPPED, '0, '0, 1'b1));
                else
                begin
                    e.end_time = it.end_time;
                    e.timer_id = it.timer_id;
                    e.buff_id  = it.buff_id;
                    pos = 0;
                    // equal end times go behind the ones already queued
                    while (pos < pending_timers.size() &&
                           pending_timers[pos].end_time <= it.end_time)
                        pos++;
                    pending_timers.insert(pos, e);
                    step_results.insert(step_results.size(),
                                        make_result(RES_ACCEPTED, '0, '0, 1'b1));
                end
            end
            KIND_EXPIRE:
            begin
                n = 0;
                while (pending_timers.size() > 0 && n < MAX_OUT &&
                       pending_timers[0].end_time <= it.now_time)
                begin
                    e = pending_timers.pop_front();
                    step_results.insert(step_results.size(),
                                        make_result(RES_EXPIRED, e.timer_id, e.buff_id, 1'b0));
                    n++;
                end
                if (n == 0)
                    step_results.insert(step_results.size(),
                                        make_result(RES_NONE, '0, '0, 1'b1));
                else
                begin
                    r = step_results.pop_back();
                    r.last = 1'b1;
                    step_results.insert(step_results.size(), r);
                end
            end
            KIND_CLEAR:
            begin
                pending_timers.delete();
                step_results.insert(step_results.size(),
                                    make_result(RES_CLEARED, '0, '0, 1'b1));
            end
            default:
            begin
            end
        endcase
    endfunction

    // Sender: bursts of transfers with random gaps; a marked row waits for an idle queue.
    always @(posedge clk)
    begin
        if (rst_n && !feed_done)
        begin
            if (in_valid && !in_stall)
            begin
                model_timer_op(in_item);
                if (stim_rows[stim_idx].typed)
                    due_results.insert(due_results.size(), stim_rows[stim_idx].result);
                else
                    foreach (step_results[i])
                        due_results.insert(due_results.size(), step_results[i]);
                stim_idx++;
                transfers++;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 16);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            if (!in_valid || !in_stall)
            begin
                if (stim_idx >= stim_rows.size())
                begin
                    in_valid  <= 1'b0;
                    feed_done <= 1'b1;
                end
                else if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (stim_rows[stim_idx].wait_idle && due_results.size() != 0)
                    in_valid <= 1'b0;
                else
                begin
                    in_valid <= 1'b1;
                    in_item  <= stim_rows[stim_idx].item;
                end
            end
        end
    end

    // Receiver: stall modes of random length, plus one long hold-off to back up the queue.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && transfers >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(20, 120);
                end
                mode_left--;
                phase_cnt++;
                case (stall_mode)
                    STALL_NEVER: out_stall <= 1'b0;
                    STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
                    default:     out_stall <= ((phase_cnt % 5) < 2);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_results.size() == 0)
            begin
                $error("unexpected result: result_kind %0d id %h buff %h last %b",
                       out_item.result_kind, out_item.expired_id,
                       out_item.expired_buff, out_item.last);
                fail_count++;
            end
            else
            begin
                oldest_due = due_results.pop_front();
                if (out_item.result_kind !== oldest_due.result_kind)
                begin
                    $error("result_kind: expected %0d, got %0d",
                           oldest_due.result_kind, out_item.result_kind);
                    fail_count++;
                end
                if (out_item.expired_id !== oldest_due.expired_id)
                begin
                    $error("expired_id: expected %h, got %h",
                           oldest_due.expired_id, out_item.expired_id);
                    fail_count++;
                end
                if (out_item.expired_buff !== oldest_due.expired_buff)
                begin
                    $error("expired_buff: expected %h, got %h",
                           oldest_due.expired_buff, out_item.expired_buff);
                    fail_count++;
                end
                if (out_item.last !== oldest_due.last)
                begin
                    $error("last: expected %b, got %b", oldest_due.last, out_item.last);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        logic [47:0] t;
        logic [1:0]  k;
        int unsigned counted;
        int unsigned n;
        int unsigned choice;
        bit          filled;

        // Empty store: expire at both time extremes and clear.
        add_row(pack_item(KIND_EXPIRE, '0, '0, '0, '0), 1'b1, RES_NONE, 1'b0);
        add_row(pack_item(KIND_EXPIRE, '1, '1, '1, TIME_MAX), 1'b1, RES_NONE, 1'b0);
        add_row(pack_item(KIND_CLEAR, '0, '0, '0, '0), 1'b1, RES_CLEARED, 1'b0);
        add_row(pack_item(KIND_ADD, 32'hFFFF_FFFF, 32'h0, TIME_MAX, '0), 1'b1, RES_ACCEPTED, 1'b0);
        add_row(pack_item(KIND_ADD, 32'h0, 32'hFFFF_FFFF, 48'h0, TIME_MAX), 1'b1,
                RES_ACCEPTED, 1'b0);
        add_row(pack_item(KIND_ADD, 32'h1, 32'h2, 48'd100, '0), 1'b0, RES_ACCEPTED, 1'b0);
        // same end time as the one before: must come out behind it
        add_row(pack_item(KIND_ADD, 32'h3, 32'h4, 48'd100, '0), 1'b0, RES_ACCEPTED, 1'b0);
        add_row(pack_item(KIND_ADD, 32'h5, 32'h6, 48'd50, '0), 1'b0, RES_ACCEPTED, 1'b0);
        add_row(pack_item(KIND_UNUSED, '1, '1, '1, '1), 1'b0, RES_ACCEPTED, 1'b0);
        add_row(pack_item(KIND_EXPIRE, '0, '0, '0, 48'd99), 1'b0, RES_ACCEPTED, 1'b0);
        add_row(pack_item(KIND_EXPIRE, '0, '0, '0, 48'd100), 1'b0, RES_ACCEPTED, 1'b0);
        add_row(pack_item(KIND_EXPIRE, '0, '0, '0, TIME_MAX - 1), 1'b1, RES_NONE, 1'b0);
        add_row(pack_item(KIND_EXPIRE, '0, '0, '0, TIME_MAX), 1'b0, RES_ACCEPTED, 1'b0);
        add_row(pack_item(KIND_ADD, 32'h7, 32'h8, 48'd10, '0), 1'b0, RES_ACCEPTED, 1'b0);
        add_row(pack_item(KIND_CLEAR, '1, '1, '1, '1), 1'b1, RES_CLEARED, 1'b0);
        add_row(pack_item(KIND_EXPIRE, '0, '0, '0, TIME_MAX), 1'b1, RES_NONE, 1'b0);
        add_row(pack_item(KIND_ADD, 32'hAAAA_5555, 32'h5555_AAAA, 48'h0, TIME_MAX), 1'b0,
                RES_ACCEPTED, 1'b0);
        add_row(pack_item(KIND_EXPIRE, '1, '1, TIME_MAX, 48'h0), 1'b0, RES_ACCEPTED, 1'b0);

        // Random part: mostly add runs near a moving time base closed by an expire.
        t = {1'b0, 15'($urandom), 32'($urandom)};
        counted = 0;
        filled = 1'b0;
        while (counted < RANDOM_ITEMS)
        begin
            choice = $urandom_range(0, 9);
            if ((choice == 9 || counted >= FILL_AT) && !filled)
            begin
                // fill past capacity after an idle pause, then expire them all at once
                filled = 1'b1;
                add_row(pack_item(KIND_CLEAR, $urandom, $urandom, rand48(), rand48()), 1'b0,
                        RES_CLEARED, 1'b1);
                for (int i = 0; i < CAPACITY + 2; i++)
                    add_row(pack_item(KIND_ADD, $urandom, $urandom, t + $urandom_range(0, 40),
                                      rand48()), 1'b0, RES_ACCEPTED, 1'b0);
                add_row(pack_item(KIND_EXPIRE, $urandom, $urandom, rand48(), t + 40), 1'b0,
                        RES_ACCEPTED, 1'b0);
                counted += CAPACITY + 4;
                t += 41;
            end
            else if (choice <= 5 || choice == 9)
            begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                    add_row(pack_item(KIND_ADD, $urandom, $urandom, t + $urandom_range(0, 15),
                                      rand48()), 1'b0, RES_ACCEPTED,
                            (i == 0) && ($urandom_range(0, 9) == 0));
                add_row(pack_item(KIND_EXPIRE, $urandom, $urandom, rand48(),
                                  t + $urandom_range(0, 20)), 1'b0, RES_ACCEPTED, 1'b0);
                counted += n + 1;
                t += $urandom_range(0, 20);
            end
            else if (choice == 6)
            begin
                k = 2'($urandom_range(0, 3));
                add_row(pack_item(k, $urandom, $urandom, rand48(), rand48()), 1'b0,
                        RES_ACCEPTED, 1'b0);
                if (k != KIND_UNUSED)
                    counted++;
            end
            else if (choice == 7)
            begin
                add_row(pack_item(KIND_CLEAR, $urandom, $urandom, rand48(), rand48()), 1'b0,
                        RES_CLEARED, 1'b0);
                counted++;
            end
            else
            begin
                add_row(pack_item(KIND_EXPIRE, $urandom, $urandom, rand48(), TIME_MAX), 1'b0,
                        RES_ACCEPTED, 1'b0);
                counted++;
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (!(feed_done && due_results.size() == 0))
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> sorted_expiry_timer_queue.f
design/setq_pkg.sv
design/setq_cell.sv
design/sorted_expiry_timer_queue.sv
sim/tb_sorted_expiry_timer_queue.sv
